>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker of the thermostat window block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define TWKS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define TWKS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/twks_pkg.sv
// Package with the key codes, limits, zone and request codes and digit helpers of the thermostat block.
`default_nettype none

package twks_pkg;

    localparam logic [7:0] KEY_SET     = 8'h1B;
    localparam logic [7:0] KEY_BACK    = 8'h0D;
    localparam logic [7:0] KEY_DIGIT_0 = 8'h30;
    localparam logic [7:0] KEY_DIGIT_9 = 8'h39;

    localparam logic [6:0] LIMIT_MAX       = 7'd99;
    localparam logic [6:0] UPPER_RESET     = 7'd28;
    localparam logic [6:0] LOWER_RESET     = 7'd20;
    localparam logic [2:0] COUNT_MAX       = 3'd5;
    localparam logic [2:0] COUNT_LAST_UP   = 3'd1;
    localparam logic [2:0] COUNT_LAST_LOW  = 3'd3;
    localparam logic [2:0] COUNT_LAST_BACK = 3'd4;

    typedef enum logic [1:0] {
        ZONE_BELOW  = 2'd0,
        ZONE_INSIDE = 2'd1,
        ZONE_ABOVE  = 2'd2
    } zone_t;

    typedef enum logic {
        REQ_SAMPLE = 1'b0,
        REQ_KEY    = 1'b1
    } req_t;

    // Appends a decimal digit to a limit and saturates at the largest limit.
    function automatic logic [6:0] push_digit(input logic [6:0] value, input logic [3:0] digit);
        logic [9:0] sum;
        sum = {3'b000, value} * 10'd10 + {6'b000000, digit};
        return (sum > {3'b000, LIMIT_MAX}) ? LIMIT_MAX : sum[6:0];
    endfunction

    // Divides a limit of at most 99 by ten through a scaled reciprocal (205 / 2048).
    function automatic logic [6:0] div_ten(input logic [6:0] value);
        logic [14:0] prod;
        prod = {8'h00, value} * 15'd205;
        return {3'b000, prod[14:11]};
    endfunction

endpackage

`default_nettype wire

>>> sv/thermostat_window_keypad_setter.sv
// Thermostat window comparator with keypad entry of the upper and lower limits.
`default_nettype none

// Each input word is either a temperature sample or a key press, chosen by
// s_axis_tuser. A sample, in sixteenths of a degree, is shifted down to whole
// degrees (rounding towards minus infinity) and classed as below the lower
// limit, inside the window, or above the upper limit; the lower limit is
// checked first. The set key enters setting mode, and pressed again it saves
// the typed limits, unless the typed upper limit is below the typed lower one,
// in which case the entry is cleared, the error light comes on and setting
// mode stays on. In setting mode the first two digits build the upper limit,
// the next two the lower limit (each saturating at 99), and backspace removes
// the last digit. Every input word yields exactly one output word showing the
// whole state after that word. The block takes one word per cycle. A word
// accepted is held in the input register until the update logic can write
// the state registers, which themselves form the output word; it does so as
// soon as the result register is free or is being emptied. While a result
// waits on m_axis_tready a new word is still taken as long as the input
// register is empty; with both registers full the input stalls until the
// result is taken.
module thermostat_window_keypad_setter
    import twks_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // tdata, lowest bit first: raw_sample[11:0], key_code[19:12], zero pad [23:20]
    input  wire logic [23:0] s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic        s_axis_tuser,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata, lowest bit first: zone[1:0], whole_degrees[9:2], setting_mode[10],
    // error_light[11], upper_active[18:12], lower_active[25:19],
    // upper_typed[32:26], lower_typed[39:33], digits_typed[42:40], zero pad [47:43]
    output      logic [47:0] m_axis_tdata
);

    // Input register.
    logic        in_valid_reg;
    logic        in_req_reg;
    logic [11:0] in_raw_reg;
    logic [7:0]  in_key_reg;

    // State registers, which are also the output word.
    logic        out_valid_reg;
    logic        setting_reg,  setting_next;
    zone_t       zone_reg,     zone_next;
    logic [7:0]  degrees_reg,  degrees_next;
    logic [6:0]  upper_reg,    upper_next;
    logic [6:0]  lower_reg,    lower_next;
    logic [6:0]  upper_ent_reg, upper_ent_next;
    logic [6:0]  lower_ent_reg, lower_ent_next;
    logic [2:0]  count_reg,    count_next;
    logic        error_reg,    error_next;

    logic        advance;
    logic        is_digit;
    logic [3:0]  digit;
    logic [2:0]  count_dec;
    logic [7:0]  whole;

    // The word in the input register moves on when the result register is free
    // or is being emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg <= s_axis_tuser;
            in_raw_reg <= s_axis_tdata[11:0];
            in_key_reg <= s_axis_tdata[19:12];
        end
    end

    // The top eight bits of the sample are its arithmetic shift right by four.
    assign whole     = in_raw_reg[11:4];
    assign is_digit  = (in_key_reg >= KEY_DIGIT_0) && (in_key_reg <= KEY_DIGIT_9);
    assign digit     = 4'(in_key_reg - KEY_DIGIT_0);
    assign count_dec = count_reg - 3'd1;

    always_comb
    begin
        setting_next   = setting_reg;
        zone_next      = zone_reg;
        degrees_next   = degrees_reg;
        upper_next     = upper_reg;
        lower_next     = lower_reg;
        upper_ent_next = upper_ent_reg;
        lower_ent_next = lower_ent_reg;
        count_next     = count_reg;
        error_next     = error_reg;

        unique case (req_t'(in_req_reg))
            REQ_SAMPLE:
            begin
                degrees_next = whole;
                priority if ($signed({whole[7], whole}) < $signed({2'b00, lower_reg}))
                begin
                    zone_next = ZONE_BELOW;
                end
                else if ($signed({whole[7], whole}) > $signed({2'b00, upper_reg}))
                begin
                    zone_next = ZONE_ABOVE;
                end
                else
                begin
                    zone_next = ZONE_INSIDE;
                end
            end
            REQ_KEY:
            begin
                priority if (in_key_reg == KEY_SET)
                begin
                    priority if (!setting_reg)
                    begin
                        setting_next = 1'b1;
                    end
                    else if (upper_ent_reg < lower_ent_reg)
                    begin
                        count_next     = 3'd0;
                        upper_ent_next = 7'd0;
                        lower_ent_next = 7'd0;
                        error_next     = 1'b1;
                    end
                    else
                    begin
                        setting_next   = 1'b0;
                        upper_next     = upper_ent_reg;
                        lower_next     = lower_ent_reg;
                        count_next     = 3'd0;
                        upper_ent_next = 7'd0;
                        lower_ent_next = 7'd0;
                        error_next     = 1'b0;
                    end
                end
                else if (is_digit)
                begin
                    if (setting_reg)
                    begin
                        priority if (count_reg <= COUNT_LAST_UP)
                        begin
                            upper_ent_next = push_digit(upper_ent_reg, digit);
                        end
                        else if (count_reg <= COUNT_LAST_LOW)
                        begin
                            lower_ent_next = push_digit(lower_ent_reg, digit);
                        end
                        else
                        begin
                            // Beyond the fourth digit no entry changes.
                        end
                        if (count_reg < COUNT_MAX)
                        begin
                            count_next = count_reg + 3'd1;
                        end
                    end
                end
                else if (in_key_reg == KEY_BACK)
                begin
                    if (setting_reg && (count_reg != 3'd0) && (count_reg <= COUNT_LAST_BACK))
                    begin
                        count_next = count_dec;
                        if (count_dec <= COUNT_LAST_UP)
                        begin
                            upper_ent_next = div_ten(upper_ent_reg);
                        end
                        else
                        begin
                            lower_ent_next = div_ten(lower_ent_reg);
                        end
                    end
                end
                else
                begin
                    // Any other key is ignored.
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            setting_reg   <= 1'b0;
            zone_reg      <= ZONE_BELOW;
            degrees_reg   <= 8'd0;
            upper_reg     <= UPPER_RESET;
            lower_reg     <= LOWER_RESET;
            upper_ent_reg <= 7'd0;
            lower_ent_reg <= 7'd0;
            count_reg     <= 3'd0;
            error_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                setting_reg   <= setting_next;
                zone_reg      <= zone_next;
                degrees_reg   <= degrees_next;
                upper_reg     <= upper_next;
                lower_reg     <= lower_next;
                upper_ent_reg <= upper_ent_next;
                lower_ent_reg <= lower_ent_next;
                count_reg     <= count_next;
                error_reg     <= error_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, count_reg, lower_ent_reg, upper_ent_reg,
                            lower_reg, upper_reg, error_reg, setting_reg,
                            degrees_reg, zone_reg};

endmodule

`default_nettype wire

>>> sv/twks_checker.sv
// Port-level checker for the thermostat window block, bound to its top level.
`default_nettype none

`include "assert_macros.svh"

module twks_checker
    import twks_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);

    logic       out_stalled;
    logic       ranges_ok;
    logic       error_shown;
    logic       setting_on;
    logic [6:0] upper_act;
    logic [6:0] lower_act;
    logic [6:0] upper_typ;
    logic [6:0] lower_typ;
    logic [2:0] digits;

    assign out_stalled = m_axis_tvalid && !m_axis_tready;
    assign error_shown = m_axis_tvalid && m_axis_tdata[11];
    assign setting_on  = m_axis_tdata[10];
    assign upper_act   = m_axis_tdata[18:12];
    assign lower_act   = m_axis_tdata[25:19];
    assign upper_typ   = m_axis_tdata[32:26];
    assign lower_typ   = m_axis_tdata[39:33];
    assign digits      = m_axis_tdata[42:40];
    assign ranges_ok   = (upper_act <= LIMIT_MAX) && (lower_act <= LIMIT_MAX) &&
                         (upper_typ <= LIMIT_MAX) && (lower_typ <= LIMIT_MAX) &&
                         (digits <= COUNT_MAX);

    // A waiting result word stays offered and unchanged until it is taken.
    `TWKS_ASSERT_NEXT(a_valid_hold, out_stalled, m_axis_tvalid, "stalled word withdrawn")
    `TWKS_ASSERT_NEXT(a_data_hold, out_stalled, $stable(m_axis_tdata), "stalled word changed")

    // A save never leaves the active window inverted.
    `TWKS_ASSERT_NOW(a_window_order, m_axis_tvalid, lower_act <= upper_act, "window inverted")

    // Limits stay within two decimal digits and the digit count saturates.
    `TWKS_ASSERT_NOW(a_ranges, m_axis_tvalid, ranges_ok, "limit or digit count out of range")

    // The error light is only lit while setting mode is on.
    `TWKS_ASSERT_NOW(a_error_in_setting, error_shown, setting_on, "error light outside setting")

endmodule

bind thermostat_window_keypad_setter twks_checker u_twks_checker (.*);

`default_nettype wire

>>> verif/thermostat_checker.sv
// Checker that predicts every status word of the thermostat block and compares it on arrival.
`timescale 1ns / 100ps

module thermostat_checker
    import twks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // raw_sample[11:0], key_code[19:12], zero pad
    input  logic        s_axis_tuser,   // req_type[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // zone, whole_degrees, ..., digits_typed, zero pad
    output int          mismatches,
    output int          pending
);

    // Layout of one status word, most significant field first.
    typedef struct packed {
        logic [4:0] pad;
        logic [2:0] digits_typed;
        logic [6:0] lower_typed;
        logic [6:0] upper_typed;
        logic [6:0] lower_active;
        logic [6:0] upper_active;
        logic       error_light;
        logic       setting_mode;
        logic [7:0] whole_degrees;
        logic [1:0] zone;
    } status_word_t;

    status_word_t expected_status[$];

    logic       setting_on;
    logic [1:0] zone_now;
    logic [7:0] degrees_now;
    logic [6:0] upper_in_use;
    logic [6:0] lower_in_use;
    logic [6:0] upper_keyed;
    logic [6:0] lower_keyed;
    logic [2:0] keyed_count;
    logic       error_on;
    int         results_seen;

    function automatic logic [6:0] append_digit(input logic [6:0] value, input logic [7:0] key);
        int total;
        total = int'(value) * 10 + int'(key - KEY_DIGIT_0);
        return (total > int'(LIMIT_MAX)) ? LIMIT_MAX : 7'(total);
    endfunction

    // Advances the predicted state by one accepted word and queues the status it must show.
    task automatic step_thermostat(input logic req, input logic [11:0] raw,
                                   input logic [7:0] key);
        int           whole;
        status_word_t word;
        if (req == REQ_SAMPLE) begin
            whole = $signed(raw);
            whole = whole >>> 4;
            degrees_now = whole[7:0];
            if (whole < int'(lower_in_use))
                zone_now = ZONE_BELOW;
            else if (whole > int'(upper_in_use))
                zone_now = ZONE_ABOVE;
            else
                zone_now = ZONE_INSIDE;
        end
        else if (key == KEY_SET) begin
            if (!setting_on) begin
                setting_on = 1'b1;
            end
            else begin
                error_on = (upper_keyed < lower_keyed);
                if (!error_on) begin
                    setting_on   = 1'b0;
                    upper_in_use = upper_keyed;
                    lower_in_use = lower_keyed;
                end
                upper_keyed = '0;
                lower_keyed = '0;
                keyed_count = '0;
            end
        end
        else if (key >= KEY_DIGIT_0 && key <= KEY_DIGIT_9) begin
            if (setting_on) begin
                if (keyed_count <= COUNT_LAST_UP)
                    upper_keyed = append_digit(upper_keyed, key);
                else if (keyed_count <= COUNT_LAST_LOW)
                    lower_keyed = append_digit(lower_keyed, key);
                if (keyed_count < COUNT_MAX)
                    keyed_count++;
            end
        end
        else if (key == KEY_BACK) begin
            if (setting_on && keyed_count >= 1 && keyed_count <= COUNT_LAST_BACK) begin
                keyed_count--;
                if (keyed_count <= COUNT_LAST_UP)
                    upper_keyed = 7'(upper_keyed / 10);
                else
                    lower_keyed = 7'(lower_keyed / 10);
            end
        end
        word.pad           = '0;
        word.digits_typed  = keyed_count;
        word.lower_typed   = lower_keyed;
        word.upper_typed   = upper_keyed;
        word.lower_active  = lower_in_use;
        word.upper_active  = upper_in_use;
        word.error_light   = error_on;
        word.setting_mode  = setting_on;
        word.whole_degrees = degrees_now;
        word.zone          = zone_now;
        expected_status.push_back(word);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            if (mismatches < 10)
                $display("%0t: status word %0d, %s expected %0d, got %0d",
                         $time, results_seen, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : watch
        status_word_t seen;
        status_word_t want;
        if (!rst_n) begin
            setting_on   = 1'b0;
            zone_now     = ZONE_BELOW;
            degrees_now  = '0;
            upper_in_use = UPPER_RESET;
            lower_in_use = LOWER_RESET;
            upper_keyed  = '0;
            lower_keyed  = '0;
            keyed_count  = '0;
            error_on     = 1'b0;
            results_seen = 0;
            mismatches   = 0;
            expected_status.delete();
        end
        else begin
            // A result always belongs to an earlier word, so compare before predicting.
            if (m_axis_tvalid && m_axis_tready) begin
                seen = m_axis_tdata;
                if (expected_status.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: status word %0d arrived with nothing predicted",
                                 $time, results_seen);
                    mismatches++;
                end
                else begin
                    want = expected_status.pop_front();
                    check_field("zone", 8'(want.zone), 8'(seen.zone));
                    check_field("whole_degrees", want.whole_degrees, seen.whole_degrees);
                    check_field("setting_mode", 8'(want.setting_mode), 8'(seen.setting_mode));
                    check_field("error_light", 8'(want.error_light), 8'(seen.error_light));
                    check_field("upper_active", 8'(want.upper_active), 8'(seen.upper_active));
                    check_field("lower_active", 8'(want.lower_active), 8'(seen.lower_active));
                    check_field("upper_typed", 8'(want.upper_typed), 8'(seen.upper_typed));
                    check_field("lower_typed", 8'(want.lower_typed), 8'(seen.lower_typed));
                    check_field("digits_typed", 8'(want.digits_typed), 8'(seen.digits_typed));
                    check_field("padding", 8'(want.pad), 8'(seen.pad));
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
                step_thermostat(s_axis_tuser, s_axis_tdata[11:0], s_axis_tdata[19:12]);
        end
        pending = expected_status.size();
    end

endmodule

>>> verif/testbench.sv
// Top of the thermostat testbench: clock, reset, word traffic on both sides and the verdict.
`timescale 1ns / 100ps

module testbench;
    import twks_pkg::*;

    // Samples and set, backspace and digit key presses count; unknown keys are not counted.
    localparam int WORD_TARGET = 650;
    // Length of the one long back-pressure stretch on the result side, in cycles.
    localparam int LONG_HOLD = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    int mismatches;
    int pending;
    int words_sent = 0;

    // When set, neither side inserts idle cycles, so words flow back to back.
    bit quiet = 1'b0;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit long_hold_req = 1'b0;

    // The clock runs at 50 MHz.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    thermostat_window_keypad_setter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    thermostat_checker status_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // Offers one input word. The task is entered and left at a falling edge, and it
    // waits for the handshake rather than for a fixed number of cycles. The callers
    // fill the field that the request type leaves unused with random bits.
    task automatic send_word(input req_t req, input logic [11:0] raw, input logic [7:0] key);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'h0, key, raw};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        if (req == REQ_SAMPLE || key == KEY_SET || key == KEY_BACK ||
            (key >= KEY_DIGIT_0 && key <= KEY_DIGIT_9))
            words_sent++;
    endtask

    task automatic feed_sample(input logic [11:0] raw);
        send_word(REQ_SAMPLE, raw, 8'($urandom));
    endtask

    task automatic press(input logic [7:0] key);
        send_word(REQ_KEY, 12'($urandom), key);
    endtask

    function automatic logic [7:0] digit_key(input int value);
        return KEY_DIGIT_0 + 8'(value);
    endfunction

    // Half of the samples lie in the sensor's stated range, many sit close to the
    // edges of any window the keypad can set, and the rest are any 12-bit pattern.
    function automatic logic [11:0] pick_raw();
        int choice;
        choice = $urandom_range(0, 9);
        if (choice < 5)
            return 12'($urandom_range(0, 2880) - 880);
        else if (choice < 8)
            return 12'(($urandom_range(0, 103) - 2) * 16 + $urandom_range(0, 15));
        else
            return 12'($urandom);
    endfunction

    // One pass through the keypad: the set key, a run of digits with the odd
    // backspace and sample in between, and the set key again to save. Random
    // digits leave the upper limit below the lower one about half the time, so
    // both the good save and the refused save come up often.
    task automatic enter_limits();
        int count;
        count = ($urandom_range(0, 9) < 6) ? 4 : $urandom_range(0, 5);
        press(KEY_SET);
        for (int i = 0; i < count; i++)
        begin
            press(digit_key($urandom_range(0, 9)));
            if ($urandom_range(0, 5) == 0)
                press(KEY_BACK);
            if ($urandom_range(0, 7) == 0)
                feed_sample(pick_raw());
        end
        press(KEY_SET);
    endtask

    // Result side. For every word it draws an idle time, keeps tready low for it,
    // then waits for the handshake. Once, on request, it holds off for a long
    // stretch so that the block fills up and stops accepting input words.
    initial
    begin : result_sink
        int wait_cycles;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold_req = 1'b0;
            end
            wait_cycles = quiet ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        int  scenario;
        bit  held_once;
        bit  drained_once;
        held_once    = 1'b0;
        drained_once = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Samples at the ends of the stated range and of the
        // 12-bit field, and on both sides of each edge of the reset window.
        feed_sample(12'd2000);
        feed_sample(-12'sd880);
        feed_sample(12'h7FF);
        feed_sample(12'h800);
        feed_sample(12'd320);
        feed_sample(12'd463);
        feed_sample(12'd319);
        feed_sample(12'd464);
        // Digits, backspace and an unknown key outside setting mode are ignored.
        press(KEY_BACK);
        press(digit_key(5));
        press(8'hFF);
        // Enter setting mode; backspace with no digits typed does nothing.
        press(KEY_SET);
        press(KEY_BACK);
        // Upper limit 99, lower limit 0, then a fifth digit saturates the count
        // and backspace at the saturated count does nothing.
        press(digit_key(9));
        press(digit_key(9));
        press(digit_key(0));
        press(digit_key(0));
        press(digit_key(7));
        press(KEY_BACK);
        press(digit_key(9));
        press(KEY_SET);
        // A save with upper limit 10 and a one-digit lower limit of 2 is accepted
        // and leaves setting mode.
        press(KEY_SET);
        press(digit_key(1));
        press(digit_key(0));
        press(digit_key(2));
        press(KEY_SET);

        // Random part, in scenarios, with whole scenarios now and then run
        // without any idle cycles on either side.
        while (words_sent < WORD_TARGET)
        begin
            quiet = ($urandom_range(0, 9) == 0);
            if (!held_once && words_sent > 250)
            begin
                // Keep offering words while the result side holds off.
                held_once     = 1'b1;
                quiet         = 1'b1;
                long_hold_req = 1'b1;
                repeat (12) feed_sample(pick_raw());
            end
            else if (!drained_once && words_sent > 450)
            begin
                // Go quiet until every predicted status word has come out.
                drained_once = 1'b1;
                s_axis_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            scenario = $urandom_range(0, 9);
            if (scenario < 5)
                enter_limits();
            else if (scenario < 8)
                repeat ($urandom_range(1, 6)) feed_sample(pick_raw());
            else
                press(8'($urandom));
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A correct run needs well under a millisecond, even with every word
    // waiting out the longest gap and the longest stall.
    initial
    begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
